@@ sv/mlk_pkg.sv @@
// ----------------------------------------------------------------------------
// mlk_pkg: shared definitions for the Morse LED keyer
// Field widths, register indexes, opcodes and the Morse pattern lookup.
// ----------------------------------------------------------------------------
package mlk_pkg;

   // Fixed field widths.
   localparam int CHAR_W      = 8;
   localparam int TIME_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int RSP_DATA_W  = 8;
   localparam int PAT_BITS_W  = 5;
   localparam int PAT_LEN_W   = 3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DASH_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS  = 2'd2;

   // Register reset values.
   localparam logic [TIME_W-1:0] DOT_TICKS_RESET  = 16'd25;
   localparam logic [TIME_W-1:0] DASH_TICKS_RESET = 16'd100;
   localparam logic [TIME_W-1:0] GAP_TICKS_RESET  = 16'd25;

   // Request opcodes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // One Morse pattern: bit i is symbol i (1 = dash), sent from bit 0 up.
   typedef struct packed {
      logic                  known;
      logic [PAT_BITS_W-1:0] bits;
      logic [PAT_LEN_W-1:0]  len;
   } mlk_pattern_type;

   typedef logic [PAT_BITS_W+PAT_LEN_W-1:0] mlk_entry_type;

   // Letters a..z, packed as {bits, len}.
   localparam mlk_entry_type LETTER_PAT [26] = '{
      {5'b00010, 3'd2}, {5'b00001, 3'd4}, {5'b00101, 3'd4}, {5'b00001, 3'd3},
      {5'b00000, 3'd1}, {5'b00100, 3'd4}, {5'b00011, 3'd3}, {5'b00000, 3'd4},
      {5'b00000, 3'd2}, {5'b01110, 3'd4}, {5'b00101, 3'd3}, {5'b00010, 3'd4},
      {5'b00011, 3'd2}, {5'b00001, 3'd2}, {5'b00111, 3'd3}, {5'b00110, 3'd4},
      {5'b01011, 3'd4}, {5'b00010, 3'd3}, {5'b00000, 3'd3}, {5'b00001, 3'd1},
      {5'b00100, 3'd3}, {5'b01000, 3'd4}, {5'b00110, 3'd3}, {5'b01001, 3'd4},
      {5'b01101, 3'd4}, {5'b00011, 3'd4}
   };

   // Digits 0..9, all five symbols long.
   localparam mlk_entry_type DIGIT_PAT [10] = '{
      {5'b11111, 3'd5}, {5'b11110, 3'd5}, {5'b11100, 3'd5}, {5'b11000, 3'd5},
      {5'b10000, 3'd5}, {5'b00000, 3'd5}, {5'b00001, 3'd5}, {5'b00011, 3'd5},
      {5'b00111, 3'd5}, {5'b01111, 3'd5}
   };

   // Look up the pattern of one ASCII code; unknown codes return known = 0.
   function automatic mlk_pattern_type mlk_lookup(input logic [CHAR_W-1:0] ch);
      mlk_pattern_type pat;
      logic [CHAR_W-1:0] offset;
      pat    = '0;
      offset = '0;
      if (ch inside {[8'h61:8'h7A]}) begin
         offset = ch - 8'h61;
         pat    = {1'b1, LETTER_PAT[offset[4:0]]};
      end else if (ch inside {[8'h30:8'h39]}) begin
         offset = ch - 8'h30;
         pat    = {1'b1, DIGIT_PAT[offset[3:0]]};
      end
      return pat;
   endfunction

endpackage

@@ sv/morse_led_keyer.sv @@
// ----------------------------------------------------------------------------
// morse_led_keyer: Morse code encoder driving one LED from tick items
// Looks up the pattern of a loaded character and plays it on tick items.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one item per transaction: req_tuser is the
//   opcode (0 loads the character in req_tdata, 1 is one time tick). Every
//   accepted item yields exactly one rsp transaction with the LED level,
//   the busy flag and the rejected and unknown-character flags. The csr channel writes
//   the dot, dash and gap times (in ticks); the user must do so only while the block is
//   idle (not enforced); csr_ready is always high and unknown indexes are ignored.
// Response and throughput:
//   Each item updates the keyer state and the response register in one
//   pass, so its response is valid in the cycle after acceptance, and one
//   item is taken every cycle while rsp_tready stays high.
// Reset and stalls:
//   Reset returns the keyer to idle with the LED off, restores the default
//   times and empties the response register. While the receiver holds
//   rsp_tready low, the response holds and req_tready drops until it is
//   taken; when it is taken, a new item is accepted in the same cycle.
// ----------------------------------------------------------------------------
module morse_led_keyer #(
   parameter int MAX_SYMBOLS = 5,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mlk_pkg::CHAR_W-1:0]       req_tdata,   // [7:0] character
   input  logic                             req_tuser,   // [0] opcode
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mlk_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [0] led_on, [1] busy_res,
                                                         // [2] rejected, [3] unknown_char
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mlk_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mlk_pkg::TIME_W-1:0]       csr_data
);
   import mlk_pkg::*;

   localparam int LEFT_W = $clog2(MAX_SYMBOLS + 1);

   // Largest time a counter holds, seen as a register value.
   localparam logic [TIME_W-1:0] CNT_MAX16 = (COUNT_WIDTH >= TIME_W) ? {TIME_W{1'b1}} :
      TIME_W'((17'd1 << COUNT_WIDTH) - 17'd1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_ON   = 3'b010,
      PH_GAP  = 3'b100
   } phase_type;

   // Clamp a register time to the counter range, zero counting as one tick.
   function automatic logic [COUNT_WIDTH-1:0] fit_time(input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] sat;
      sat = (t > CNT_MAX16) ? CNT_MAX16 : t;
      if (sat == '0) begin
         sat = TIME_W'(1);
      end
      return COUNT_WIDTH'(sat);
   endfunction

   logic [TIME_W-1:0]      dot_ticks_ff, dash_ticks_ff, gap_ticks_ff;
   logic [MAX_SYMBOLS-1:0] bits_ff, bits_in, bits_shift;
   logic [LEFT_W-1:0]      left_ff, left_in, left_dec;
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_dec;
   logic                   led_ff, led_in;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   accept, rej, unk, busy_in;
   mlk_pattern_type        pat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;
   assign pat        = mlk_lookup(req_tdata);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ticks_ff  <= DOT_TICKS_RESET;
         dash_ticks_ff <= DASH_TICKS_RESET;
         gap_ticks_ff  <= GAP_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DOT_TICKS:  dot_ticks_ff  <= csr_data;
            CSR_DASH_TICKS: dash_ticks_ff <= csr_data;
            CSR_GAP_TICKS:  gap_ticks_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Next keyer state for the accepted item.
   always_comb begin
      bits_in    = bits_ff;
      left_in    = left_ff;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      led_in     = led_ff;
      rej        = 1'b0;
      unk        = 1'b0;
      cnt_dec    = (cnt_ff != '0) ? cnt_ff - COUNT_WIDTH'(1) : '0;
      bits_shift = bits_ff >> 1;
      left_dec   = left_ff - LEFT_W'(1);
      if (accept) begin
         if (req_tuser == OP_LOAD) begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else if (pat.known) begin
               bits_in  = MAX_SYMBOLS'(pat.bits);
               left_in  = LEFT_W'(pat.len);
               phase_in = PH_ON;
               led_in   = 1'b1;
               cnt_in   = fit_time(pat.bits[0] ? dash_ticks_ff : dot_ticks_ff);
            end else begin
               unk = 1'b1;
            end
         end else if (phase_ff != PH_IDLE) begin
            cnt_in = cnt_dec;
            if (cnt_dec == '0) begin
               if (phase_ff == PH_ON) begin
                  // On time over: start the gap.
                  phase_in = PH_GAP;
                  led_in   = 1'b0;
                  cnt_in   = fit_time(gap_ticks_ff);
               end else if (left_dec != '0) begin
                  // Gap over: start the next symbol.
                  bits_in  = bits_shift;
                  left_in  = left_dec;
                  phase_in = PH_ON;
                  led_in   = 1'b1;
                  cnt_in   = fit_time(bits_shift[0] ? dash_ticks_ff : dot_ticks_ff);
               end else begin
                  // Last gap over: back to idle.
                  bits_in  = '0;
                  left_in  = left_dec;
                  phase_in = PH_IDLE;
                  led_in   = 1'b0;
               end
            end
         end
      end
      busy_in     = (phase_in != PH_IDLE);
      rsp_data_in = {4'b0000, unk, rej, busy_in, led_in};
   end

   // Keyer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         left_ff  <= '0;
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         led_ff   <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         left_ff  <= left_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         led_ff   <= led_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ sv/mlk_checker.sv @@
// ----------------------------------------------------------------------------
// mlk_checker: port-level checks for the Morse LED keyer
// Watches the response channel and the relations between its flags.
// ----------------------------------------------------------------------------
module mlk_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mlk_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mlk_pkg::*;

   // The response register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its flags.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A dropped load leaves the keyer busy and is never also flagged unknown.
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1] && !rsp_tdata[3])
      else $error("rejected load without busy keyer");

   // An unknown character leaves the keyer idle with the LED off.
   a_unknown_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[1] && !rsp_tdata[0])
      else $error("unknown character started a pattern");

   // The LED is only lit while a pattern plays.
   a_led_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("LED on while idle");

endmodule

bind morse_led_keyer mlk_checker u_mlk_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
